[hdl/sfap_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite frame player package
// Shared widths, codes and structures of the sprite frame animation player.
// ----------------------------------------------------------------------------
package sfap_pkg;

    localparam int FRAMES_DEF  = 16;
    localparam int TABLE_DEPTH = 16;
    localparam int FRAME_W     = 4;
    localparam int POS_W       = 24;
    localparam int DUR_W       = 16;
    localparam int SPEED_W     = 16;
    localparam int PRIO_W      = 8;
    localparam int ID_W        = 8;
    localparam int COUNT_W     = 5;

    localparam logic [SPEED_W-1:0] SPEED_NORMAL = 16'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd16;

    // Run states
    localparam logic [1:0] RUN_PAUSED = 2'd0;
    localparam logic [1:0] RUN_FWD    = 2'd1;
    localparam logic [1:0] RUN_BWD    = 2'd2;

    // Item kinds
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_MSG  = 2'd1;
    localparam logic [1:0] FUNC_LOAD = 2'd2;

    // Message actions
    localparam logic [1:0] ACT_PAUSE    = 2'd0;
    localparam logic [1:0] ACT_STOP     = 2'd1;
    localparam logic [1:0] ACT_START    = 2'd2;
    localparam logic [1:0] ACT_CONTINUE = 2'd3;

    // Loop modes
    localparam logic [1:0] LOOP_ONESHOT  = 2'd0;
    localparam logic [1:0] LOOP_REPEAT   = 2'd1;
    localparam logic [1:0] LOOP_PINGPONG = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WRAP_MODE   = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]         run;
        logic [1:0]         resume;
        logic [FRAME_W-1:0] frame;
        logic [POS_W-1:0]   pos;
        logic [SPEED_W-1:0] speed;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } anim_state_t;

    typedef struct packed {
        logic               pass;
        logic               stop;
        logic [POS_W-1:0]   pos;
        logic [FRAME_W-1:0] frame;
        logic [1:0]         run;
    } step_res_t;

endpackage

[hdl/sprite_frame_animation_player.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation player
// Plays the frames of one animated sprite from a table of frame durations.
// ----------------------------------------------------------------------------
// Each input transaction is a tick, an animation message or a duration
// load, and each produces exactly one result transaction carrying the
// current frame, the play state and a saturation flag. Loads, messages and
// ticks that find the sprite paused or the frame count zero go from
// acceptance straight to the finish state. A tick on a playing sprite runs
// the multiply state, the add state and S compare steps, where S is the
// number of frames passed plus one closing compare (at most FRAMES + 1); a
// one-shot animation that runs off its end skips the closing compare. The
// multiply state multiplies the elapsed time by the speed, the add state adds
// the product into the position, and then a single shared compare and subtract
// unit walks the frames, one frame per cycle. The input side is not ready
// while an item is in work; the result sits in an output register, so a new
// transaction can be accepted while the previous result still waits downstream.
// ----------------------------------------------------------------------------
module sprite_frame_animation_player
    import sfap_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [15:0]        delta_ms,
    input  logic [PRIO_W-1:0]  msg_priority,
    input  logic               msg_change_speed,
    input  logic [SPEED_W-1:0] msg_speed,
    input  logic [ID_W-1:0]    msg_animation_id,
    input  logic [1:0]         msg_action,
    input  logic [FRAME_W-1:0] frame_index,
    input  logic [DUR_W-1:0]   frame_ms,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FRAME_W-1:0] current_frame,
    output logic [1:0]         play_state,
    output logic               position_saturated,
    // Configuration port
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [COUNT_W-1:0] cfg_data
);

    // The step counter must be able to hold FRAMES itself.
    localparam int STEP_W = $clog2(FRAMES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]          state_reg, state_next;
    anim_state_t         anim_reg, anim_next;
    logic [DUR_W-1:0]    dur_table_reg [TABLE_DEPTH];
    logic [15:0]         delta_reg, delta_next;
    logic [31:0]         prod_reg, prod_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic                sat_reg, sat_next;
    logic [1:0]          wrap_mode_reg;
    logic [COUNT_W-1:0]  frame_count_reg;

    logic                out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic [1:0]          out_state_reg;
    logic                out_sat_reg;

    logic                in_fire;
    logic                out_load;
    anim_state_t         msg_state;
    step_res_t           step_res;
    logic [COUNT_W-1:0]  count;
    logic [FRAME_W-1:0]  last;
    logic [POS_W:0]      pos_sum;
    logic [32:0]         wide_sum;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // A frame count above the table size acts as the table size.
    assign count = (frame_count_reg > COUNT_MAX) ? COUNT_MAX : frame_count_reg;
    assign last  = FRAME_W'(count - 1'b1);

    // The position plus product saturates at the largest Q16.8 value.
    assign wide_sum = {9'd0, anim_reg.pos} + {1'b0, prod_reg};
    assign pos_sum  = (wide_sum[32:POS_W] != '0) ? {1'b1, {POS_W{1'b1}}}
                                                 : {1'b0, wide_sum[POS_W-1:0]};

    sfap_msg u_msg (
        .cur              (anim_reg),
        .msg_priority     (msg_priority),
        .msg_change_speed (msg_change_speed),
        .msg_speed        (msg_speed),
        .msg_animation_id (msg_animation_id),
        .msg_action       (msg_action),
        .nxt              (msg_state)
    );

    sfap_frame_step u_step (
        .pos       (anim_reg.pos),
        .duration  (dur_table_reg[anim_reg.frame]),
        .frame     (anim_reg.frame),
        .last      (last),
        .run       (anim_reg.run),
        .wrap_mode (wrap_mode_reg),
        .res       (step_res)
    );

    // Sequencer: messages, loads and ticks that cannot play finish at acceptance;
    // playing ticks run the multiply, the saturating add and then one frame per cycle.
    always_comb
    begin
        state_next = state_reg;
        anim_next  = anim_reg;
        delta_next = delta_reg;
        prod_next  = prod_reg;
        steps_next = steps_reg;
        sat_next   = sat_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sat_next   = 1'b0;
                    delta_next = delta_ms;
                    state_next = S_FIN;
                    if (func == FUNC_MSG)
                    begin
                        anim_next = msg_state;
                    end
                    else if (func == FUNC_TICK)
                    begin
                        if (anim_reg.run != RUN_PAUSED && count != '0)
                        begin
                            state_next = S_MUL;
                        end
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = delta_reg * anim_reg.speed;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                anim_next.pos = pos_sum[POS_W-1:0];
                sat_next      = pos_sum[POS_W];
                steps_next    = '0;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                if (!step_res.pass)
                begin
                    state_next = S_FIN;
                end
                else if (steps_reg == STEP_W'(FRAMES))
                begin
                    // Advance bound reached with time still left over.
                    sat_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    steps_next      = steps_reg + 1'b1;
                    anim_next.pos   = step_res.pos;
                    anim_next.frame = step_res.frame;
                    anim_next.run   = step_res.run;
                    if (step_res.stop)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            anim_reg.run    <= RUN_PAUSED;
            anim_reg.resume <= RUN_PAUSED;
            anim_reg.frame  <= '0;
            anim_reg.pos    <= '0;
            anim_reg.speed  <= SPEED_NORMAL;
            anim_reg.prio   <= '0;
            anim_reg.id     <= '0;
            steps_reg       <= '0;
            sat_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            wrap_mode_reg   <= LOOP_REPEAT;
            frame_count_reg <= '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                dur_table_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            anim_reg      <= anim_next;
            steps_reg     <= steps_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (in_fire && func == FUNC_LOAD)
            begin
                dur_table_reg[frame_index] <= frame_ms;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WRAP_MODE:   wrap_mode_reg   <= cfg_data[1:0];
                    CFG_FRAME_COUNT: frame_count_reg <= cfg_data;
                    default:         wrap_mode_reg   <= wrap_mode_reg;
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        prod_reg  <= prod_next;
        if (out_load)
        begin
            out_frame_reg <= anim_reg.frame;
            out_state_reg <= anim_reg.run;
            out_sat_reg   <= sat_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign current_frame      = out_frame_reg;
    assign play_state         = out_state_reg;
    assign position_saturated = out_sat_reg;

endmodule

[hdl/sfap_msg.sv]
// ----------------------------------------------------------------------------
// Animation message decoder
// Computes the player state after an animation message.
// ----------------------------------------------------------------------------
module sfap_msg
    import sfap_pkg::*;
(
    input  anim_state_t        cur,
    input  logic [PRIO_W-1:0]  msg_priority,
    input  logic               msg_change_speed,
    input  logic [SPEED_W-1:0] msg_speed,
    input  logic [ID_W-1:0]    msg_animation_id,
    input  logic [1:0]         msg_action,
    output anim_state_t        nxt
);

    logic       accept;
    logic [1:0] act;

    always_comb
    begin
        nxt    = cur;
        act    = msg_action;
        accept = (msg_priority >= cur.prio) || (cur.run == RUN_PAUSED);
        if (accept)
        begin
            if (msg_change_speed)
            begin
                nxt.speed = msg_speed;
            end
            // A different animation turns continue into a restart from the first frame.
            if (msg_animation_id != cur.id)
            begin
                nxt.id = msg_animation_id;
                if (act == ACT_CONTINUE)
                begin
                    act = ACT_START;
                end
            end
            nxt.prio = msg_priority;
            case (act)
                ACT_PAUSE:
                begin
                    if (cur.run != RUN_PAUSED)
                    begin
                        nxt.resume = cur.run;
                        nxt.run    = RUN_PAUSED;
                    end
                end
                ACT_STOP:
                begin
                    nxt.resume = RUN_PAUSED;
                    nxt.run    = RUN_PAUSED;
                    nxt.frame  = '0;
                    nxt.pos    = '0;
                end
                ACT_START:
                begin
                    nxt.run   = RUN_FWD;
                    nxt.frame = '0;
                    nxt.pos   = '0;
                end
                default:
                begin
                    if (cur.run == RUN_PAUSED)
                    begin
                        if (cur.resume == RUN_PAUSED)
                        begin
                            nxt.resume = RUN_FWD;
                            nxt.run    = RUN_FWD;
                        end
                        else
                        begin
                            nxt.run = cur.resume;
                        end
                    end
                end
            endcase
        end
    end

endmodule

[hdl/sfap_frame_step.sv]
// ----------------------------------------------------------------------------
// Frame step unit
// One compare and subtract of the position against a frame duration, and
// the frame and direction that follow in the selected loop mode.
// ----------------------------------------------------------------------------
module sfap_frame_step
    import sfap_pkg::*;
(
    input  logic [POS_W-1:0]   pos,
    input  logic [DUR_W-1:0]   duration,
    input  logic [FRAME_W-1:0] frame,
    input  logic [FRAME_W-1:0] last,
    input  logic [1:0]         run,
    input  logic [1:0]         wrap_mode,
    output step_res_t          res
);

    logic [POS_W-1:0] dur_fixed;

    assign dur_fixed = {duration, 8'd0};

    always_comb
    begin
        res.pass  = pos > dur_fixed;
        res.pos   = pos - dur_fixed;
        res.frame = frame;
        res.run   = run;
        res.stop  = 1'b0;
        case (wrap_mode)
            LOOP_PINGPONG:
            begin
                if (run == RUN_FWD)
                begin
                    if (frame < last)
                    begin
                        res.frame = frame + 1'b1;
                    end
                    else
                    begin
                        if (frame != '0)
                        begin
                            res.frame = frame - 1'b1;
                        end
                        res.run = RUN_BWD;
                    end
                end
                else
                begin
                    if (frame != '0)
                    begin
                        res.frame = frame - 1'b1;
                    end
                    else
                    begin
                        if (last != '0)
                        begin
                            res.frame = FRAME_W'(1);
                        end
                        res.run = RUN_FWD;
                    end
                end
            end
            LOOP_REPEAT:
            begin
                if (run == RUN_FWD)
                begin
                    res.frame = (frame < last) ? frame + 1'b1 : '0;
                end
                else
                begin
                    res.frame = (frame != '0) ? frame - 1'b1 : last;
                end
            end
            LOOP_ONESHOT:
            begin
                if (run == RUN_FWD)
                begin
                    if (frame < last)
                    begin
                        res.frame = frame + 1'b1;
                    end
                    else
                    begin
                        res.run  = RUN_PAUSED;
                        res.stop = 1'b1;
                    end
                end
                else
                begin
                    if (frame != '0)
                    begin
                        res.frame = frame - 1'b1;
                    end
                    else
                    begin
                        res.run  = RUN_PAUSED;
                        res.stop = 1'b1;
                    end
                end
            end
            default:
            begin
                // The unused mode consumes time but holds the frame.
            end
        endcase
    end

endmodule

[hdl/sfap_checker.sv]
// ----------------------------------------------------------------------------
// Sprite frame player checker
// Port level assertions, bound to the top level of the player.
// ----------------------------------------------------------------------------
module sfap_checker
    import sfap_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         func,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FRAME_W-1:0] current_frame,
    input logic [1:0]         play_state,
    input logic               position_saturated
);

    // A result that waits keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(current_frame)
            && $stable(play_state) && $stable(position_saturated))
    else $error("stalled result changed");

    // The player is not ready in the cycle after it takes a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input ready right after acceptance");

    // A result never reports an undefined play state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> play_state != 2'd3)
    else $error("invalid play state");

    // A result that rises once a load or message has gone through the finish
    // state belongs to that transaction and never reports saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid)
            && $past(in_valid && in_ready && (func == FUNC_MSG || func == FUNC_LOAD), 2)
            |-> !position_saturated)
    else $error("saturation reported for a non-tick transaction");

endmodule

bind sprite_frame_animation_player sfap_checker u_sfap_checker (.*);

[verif/sprite_frame_animation_player_checker.sv]
// ----------------------------------------------------------------------------
// Sprite frame player checker
// Watches the channels of the player, predicts every result and compares it.
// ----------------------------------------------------------------------------
module sprite_frame_animation_player_checker
    import sfap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         func,
    input  logic [15:0]        delta_ms,
    input  logic [PRIO_W-1:0]  msg_priority,
    input  logic               msg_change_speed,
    input  logic [SPEED_W-1:0] msg_speed,
    input  logic [ID_W-1:0]    msg_animation_id,
    input  logic [1:0]         msg_action,
    input  logic [FRAME_W-1:0] frame_index,
    input  logic [DUR_W-1:0]   frame_ms,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [FRAME_W-1:0] current_frame,
    input  logic [1:0]         play_state,
    input  logic               position_saturated,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [COUNT_W-1:0] cfg_data,
    output int                 mismatches,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [1:0]         run;
        logic               sat;
    } frame_report_t;

    frame_report_t expected_reports[$];

    // Shadow copy of the player.
    logic [1:0]         wrap_mode;
    logic [COUNT_W-1:0] frame_count;
    logic [1:0]         run_state;
    logic [1:0]         resume_state;
    logic [FRAME_W-1:0] frame_number;
    logic [POS_W-1:0]   position;
    logic [SPEED_W-1:0] speed;
    logic [PRIO_W-1:0]  held_prio;
    logic [ID_W-1:0]    anim_id;
    logic [DUR_W-1:0]   durations [TABLE_DEPTH];

    int failures = 0;
    int results_seen = 0;

    assign mismatches = failures;

    function automatic void take_message(input logic [PRIO_W-1:0] prio,
                                         input logic chg,
                                         input logic [SPEED_W-1:0] spd,
                                         input logic [ID_W-1:0] id,
                                         input logic [1:0] act);
        logic [1:0] action;
        action = act;
        if (!(prio >= held_prio || run_state == RUN_PAUSED))
            return;
        if (chg)
            speed = spd;
        if (id != anim_id)
        begin
            anim_id = id;
            if (action == ACT_CONTINUE)
                action = ACT_START;
        end
        held_prio = prio;
        case (action)
            ACT_PAUSE:
            begin
                if (run_state != RUN_PAUSED)
                begin
                    resume_state = run_state;
                    run_state    = RUN_PAUSED;
                end
            end
            ACT_STOP:
            begin
                resume_state = RUN_PAUSED;
                run_state    = RUN_PAUSED;
                frame_number = '0;
                position     = '0;
            end
            ACT_START:
            begin
                run_state    = RUN_FWD;
                frame_number = '0;
                position     = '0;
            end
            default:
            begin
                if (run_state == RUN_PAUSED)
                begin
                    if (resume_state == RUN_PAUSED)
                        resume_state = RUN_FWD;
                    run_state = resume_state;
                end
            end
        endcase
    endfunction

    // Advances the play position by one tick and walks the frames it passes.
    // Returns the saturation flag.
    function automatic logic play_tick(input logic [15:0] delta);
        logic [32:0]        sum;
        logic [POS_W-1:0]   dur;
        logic [COUNT_W-1:0] count;
        logic [FRAME_W-1:0] last;
        logic               sat;
        int                 steps;
        sat   = 1'b0;
        steps = 0;
        count = (frame_count > COUNT_MAX) ? COUNT_MAX : frame_count;
        if (run_state == RUN_PAUSED || count == 0)
            return 1'b0;
        last = FRAME_W'(count - 1);
        sum  = position + delta * speed;
        if (sum > 33'hFFFFFF)
        begin
            sum = 33'hFFFFFF;
            sat = 1'b1;
        end
        position = sum[POS_W-1:0];
        forever
        begin
            dur = {durations[frame_number], 8'd0};
            if (position <= dur)
                break;
            if (steps >= FRAMES_DEF)
            begin
                sat = 1'b1;
                break;
            end
            steps++;
            position = position - dur;
            case (wrap_mode)
                LOOP_PINGPONG:
                begin
                    if (run_state == RUN_FWD)
                    begin
                        if (frame_number < last)
                            frame_number++;
                        else
                        begin
                            if (frame_number > 0)
                                frame_number--;
                            run_state = RUN_BWD;
                        end
                    end
                    else
                    begin
                        if (frame_number > 0)
                            frame_number--;
                        else
                        begin
                            if (last > 0)
                                frame_number = FRAME_W'(1);
                            run_state = RUN_FWD;
                        end
                    end
                end
                LOOP_REPEAT:
                begin
                    if (run_state == RUN_FWD)
                        frame_number = (frame_number < last) ? frame_number + 1'b1 : '0;
                    else
                        frame_number = (frame_number > 0) ? frame_number - 1'b1 : last;
                end
                LOOP_ONESHOT:
                begin
                    if (run_state == RUN_FWD)
                    begin
                        if (frame_number < last)
                            frame_number++;
                        else
                            run_state = RUN_PAUSED;
                    end
                    else
                    begin
                        if (frame_number > 0)
                            frame_number--;
                        else
                            run_state = RUN_PAUSED;
                    end
                    if (run_state == RUN_PAUSED)
                        break;
                end
                default:
                    ;
            endcase
        end
        return sat;
    endfunction

    function automatic void note_failure(input string what, input frame_report_t want,
                                         input frame_report_t got);
        if (failures < MAX_REPORTS)
            $display("%0t: result %0d %s: expected frame %0d state %0d sat %0b, "
                     , $time, results_seen, what, want.frame, want.run, want.sat,
                     "got frame %0d state %0d sat %0b", got.frame, got.run, got.sat);
        failures++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_report_t want;
        frame_report_t got;
        if (!rst_n)
        begin
            wrap_mode    = LOOP_REPEAT;
            frame_count  = '0;
            run_state    = RUN_PAUSED;
            resume_state = RUN_PAUSED;
            frame_number = '0;
            position     = '0;
            speed        = SPEED_NORMAL;
            held_prio    = '0;
            anim_id      = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                durations[i] = '0;
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WRAP_MODE)
                    wrap_mode = cfg_data[1:0];
                else
                    frame_count = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                want.sat = 1'b0;
                case (func)
                    FUNC_TICK: want.sat = play_tick(delta_ms);
                    FUNC_MSG:  take_message(msg_priority, msg_change_speed, msg_speed,
                                            msg_animation_id, msg_action);
                    FUNC_LOAD: durations[frame_index] = frame_ms;
                    default:   ;
                endcase
                want.frame = frame_number;
                want.run   = run_state;
                expected_reports.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got.frame = current_frame;
                got.run   = play_state;
                got.sat   = position_saturated;
                if (expected_reports.size() == 0)
                    note_failure("arrived with nothing expected", '0, got);
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.frame !== want.frame || got.run !== want.run
                        || got.sat !== want.sat)
                        note_failure("mismatch", want, got);
                end
                results_seen++;
            end
            pending <= expected_reports.size();
        end
    end

endmodule

[verif/sprite_frame_animation_player_test.sv]
// ----------------------------------------------------------------------------
// Sprite frame player testbench
// Drives ticks, animation messages and duration loads into the player under
// a series of loop modes and frame counts, with random gaps on both
// channels, and lets the checker compare every result with its prediction.
// ----------------------------------------------------------------------------
module sprite_frame_animation_player_test
    import sfap_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 10;
    // Enough random input transactions to visit many configurations.
    localparam int ITEM_TARGET  = 1850;
    // The tail is long enough to cover the slowest tick twice.
    localparam int TAIL_CYCLES  = 2 * (FRAMES_DEF + 5);
    // The limit lies well above the slowest correct run: every item with
    // the longest sender gap, the longest tick and the longest receiver stall.
    localparam int CYCLE_LIMIT  = 400000;

    // Codes the package leaves unnamed; the block has no case of its own for them.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] LOOP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         kind;
        logic [15:0]        delta;
        logic [PRIO_W-1:0]  prio;
        logic               chg;
        logic [SPEED_W-1:0] speed;
        logic [ID_W-1:0]    id;
        logic [1:0]         action;
        logic [FRAME_W-1:0] index;
        logic [DUR_W-1:0]   duration;
    } player_item_t;

    logic               clk              = 1'b0;
    logic               rst_n            = 1'b0;
    logic               in_valid         = 1'b0;
    logic               in_ready;
    logic [1:0]         func             = FUNC_TICK;
    logic [15:0]        delta_ms         = '0;
    logic [PRIO_W-1:0]  msg_priority     = '0;
    logic               msg_change_speed = 1'b0;
    logic [SPEED_W-1:0] msg_speed        = '0;
    logic [ID_W-1:0]    msg_animation_id = '0;
    logic [1:0]         msg_action       = ACT_PAUSE;
    logic [FRAME_W-1:0] frame_index      = '0;
    logic [DUR_W-1:0]   frame_ms         = '0;
    logic               out_valid;
    logic               out_ready        = 1'b0;
    logic [FRAME_W-1:0] current_frame;
    logic [1:0]         play_state;
    logic               position_saturated;
    logic               cfg_we           = 1'b0;
    logic               cfg_index        = CFG_WRAP_MODE;
    logic [COUNT_W-1:0] cfg_data         = '0;

    int          mismatches;
    int          pending;
    int          cycles      = 0;
    int unsigned items_sent  = 0;
    int unsigned stall_left  = 0;
    // When set, neither side idles; whole phases run at full rate this way.
    bit          no_gaps     = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    sprite_frame_animation_player uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .delta_ms           (delta_ms),
        .msg_priority       (msg_priority),
        .msg_change_speed   (msg_change_speed),
        .msg_speed          (msg_speed),
        .msg_animation_id   (msg_animation_id),
        .msg_action         (msg_action),
        .frame_index        (frame_index),
        .frame_ms           (frame_ms),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .current_frame      (current_frame),
        .play_state         (play_state),
        .position_saturated (position_saturated),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    sprite_frame_animation_player_checker checker_inst (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .delta_ms           (delta_ms),
        .msg_priority       (msg_priority),
        .msg_change_speed   (msg_change_speed),
        .msg_speed          (msg_speed),
        .msg_animation_id   (msg_animation_id),
        .msg_action         (msg_action),
        .frame_index        (frame_index),
        .frame_ms           (frame_ms),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .current_frame      (current_frame),
        .play_state         (play_state),
        .position_saturated (position_saturated),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .pending            (pending)
    );

    // Watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side. After each accepted result transaction the receiver draws
    // a random stall during which it holds ready low, so the stall
    // lands on every phase of the next item's work.
    always @(posedge clk)
    begin
        int unsigned hold;
        if (out_valid && out_ready)
        begin
            hold = no_gaps ? 0 : $urandom_range(0, 7);
            stall_left <= hold;
            out_ready  <= (hold == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Mostly values in a playable range, now and then the full 16-bit range
    // so that every bit of the field is exercised.
    function automatic logic [15:0] pick16(input int unsigned typical);
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, typical));
    endfunction

    // Fields that the item kind does not use carry random noise; the block
    // must ignore them.
    function automatic player_item_t noise_item(input logic [1:0] kind);
        player_item_t it;
        it.kind     = kind;
        it.delta    = 16'($urandom_range(0, 65535));
        it.prio     = PRIO_W'($urandom_range(0, 255));
        it.chg      = 1'($urandom_range(0, 1));
        it.speed    = 16'($urandom_range(0, 65535));
        it.id       = ID_W'($urandom_range(0, 255));
        it.action   = 2'($urandom_range(0, 3));
        it.index    = FRAME_W'($urandom_range(0, 15));
        it.duration = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // Presents one input transaction and returns at the edge that accepts
    // it. Valid is left high on purpose: the caller either drives the next
    // item in the same time step or lowers valid, so valid is never dropped
    // and raised again within one step.
    task automatic send_item(input player_item_t it);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func             <= it.kind;
        delta_ms         <= it.delta;
        msg_priority     <= it.prio;
        msg_change_speed <= it.chg;
        msg_speed        <= it.speed;
        msg_animation_id <= it.id;
        msg_action       <= it.action;
        frame_index      <= it.index;
        frame_ms         <= it.duration;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_tick(input logic [15:0] delta);
        player_item_t it;
        it       = noise_item(FUNC_TICK);
        it.delta = delta;
        send_item(it);
    endtask

    task automatic send_message(input logic [PRIO_W-1:0] prio, input logic chg,
                                input logic [SPEED_W-1:0] speed,
                                input logic [ID_W-1:0] id, input logic [1:0] action);
        player_item_t it;
        it        = noise_item(FUNC_MSG);
        it.prio   = prio;
        it.chg    = chg;
        it.speed  = speed;
        it.id     = id;
        it.action = action;
        send_item(it);
    endtask

    task automatic send_load(input logic [FRAME_W-1:0] index,
                             input logic [DUR_W-1:0] duration);
        player_item_t it;
        it          = noise_item(FUNC_LOAD);
        it.index    = index;
        it.duration = duration;
        send_item(it);
    endtask

    // Lowers valid and waits until every expected result has been taken.
    // The first edge is always waited out, because the pending count is
    // registered and does not yet show an item accepted at the current edge.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Writes both registers back to back. Only called while the block is idle.
    task automatic configure(input logic [1:0] mode, input logic [COUNT_W-1:0] count);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WRAP_MODE;
        cfg_data  <= COUNT_W'(mode);
        @(posedge clk);
        cfg_index <= CFG_FRAME_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Hand-picked transactions: field extremes, every action and item kind,
    // and the corner cases of acceptance and stepping.
    task automatic run_directed();
        // Reset settings: repeat mode with no frames.
        send_tick(16'hFFFF);                   // tick while paused
        send_load(4'd0, 16'hFFFF);
        send_load(4'd15, 16'h0000);
        // A new animation id turns continue into start; speed goes to maximum.
        send_message(8'd0, 1'b1, 16'hFFFF, 8'hFF, ACT_CONTINUE);
        send_tick(16'hFFFF);                   // zero frames: tick does nothing
        send_item(noise_item(FUNC_UNUSED));
        send_message(8'd200, 1'b0, 16'h0000, 8'hFF, ACT_CONTINUE);
        send_message(8'd100, 1'b0, 16'h0000, 8'hFF, ACT_PAUSE);   // too low, ignored
        send_message(8'd255, 1'b0, 16'h0000, 8'hFF, ACT_PAUSE);
        send_message(8'd0, 1'b0, 16'h0000, 8'hFF, ACT_CONTINUE);  // paused, so accepted
        drain();

        // A frame count above the table size acts as the full table. The
        // product clips the position, and the walk passes the zero-length frames
        // behind frame zero and wraps back to frame zero.
        configure(LOOP_REPEAT, 5'd31);
        send_tick(16'hFFFF);
        send_tick(16'd1);
        send_message(8'd255, 1'b1, SPEED_NORMAL, 8'h00, ACT_STOP);
        drain();

        // Ping-pong over a single frame: the frame stays put and only the
        // direction flips, ending up backward here.
        configure(LOOP_PINGPONG, 5'd1);
        send_load(4'd0, 16'd1);
        send_message(8'd0, 1'b0, 16'h0000, 8'h00, ACT_START);
        send_tick(16'd2);
        send_tick(16'd0);
        drain();

        // One-shot: first running off the start while backward, then off the
        // end while forward, then resuming.
        configure(LOOP_ONESHOT, 5'd4);
        send_tick(16'd2);
        send_load(4'd2, 16'd2);
        send_message(8'd0, 1'b0, 16'h0000, 8'h00, ACT_START);
        send_tick(16'd100);
        send_message(8'd0, 1'b0, 16'h0000, 8'h00, ACT_CONTINUE);
        drain();

        // The unused loop mode eats durations but never moves the frame.
        configure(LOOP_UNUSED, 5'd16);
        send_tick(16'd50);
        drain();
    endtask

    task automatic send_random_item();
        int unsigned pick;
        logic [1:0]  action;
        logic [ID_W-1:0] id;
        pick = $urandom_range(0, 19);
        if (pick <= 10)
            send_tick(pick16(60));
        else if (pick <= 14)
        begin
            // Start and continue dominate so that the sprite keeps playing.
            case ($urandom_range(0, 5))
                0:       action = ACT_PAUSE;
                1:       action = ACT_STOP;
                2, 3:    action = ACT_START;
                default: action = ACT_CONTINUE;
            endcase
            // A few ids are reused so that continue is not always a restart.
            id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 255))
                                             : ID_W'($urandom_range(0, 3));
            send_message(PRIO_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         pick16(600), id, action);
        end
        else if (pick <= 18)
            send_load(FRAME_W'($urandom_range(0, 15)), pick16(40));
        else
            send_item(noise_item(FUNC_UNUSED));
    endtask

    // One random phase: wait for the block to go idle, pick new settings,
    // usually set up a playable animation, then send a random mix.
    task automatic run_random_phase();
        logic [1:0]         mode;
        logic [COUNT_W-1:0] count;
        int unsigned        loads;
        drain();
        no_gaps = ($urandom_range(0, 3) == 0);
        mode    = ($urandom_range(0, 9) == 0) ? LOOP_UNUSED : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 7))
            0:       count = 5'd0;
            1:       count = COUNT_W'($urandom_range(17, 31));
            2:       count = COUNT_MAX;
            3:       count = 5'd1;
            default: count = COUNT_W'($urandom_range(2, 8));
        endcase
        configure(mode, count);
        // Without a start the frame from the previous phase carries over,
        // which may now lie beyond the frame count.
        if ($urandom_range(0, 3) != 0)
        begin
            loads = $urandom_range(0, 4);
            repeat (loads)
                send_load(FRAME_W'($urandom_range(0, 15)), pick16(40));
            send_message(PRIO_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         pick16(600), ID_W'($urandom_range(0, 3)), ACT_START);
        end
        repeat ($urandom_range(15, 50))
            send_random_item();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        items_sent = 0;
        while (items_sent < ITEM_TARGET)
            run_random_phase();

        // Every result must come back, and nothing more may follow.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/sfap_pkg.sv
hdl/sfap_msg.sv
hdl/sfap_frame_step.sv
hdl/sprite_frame_animation_player.sv
hdl/sfap_checker.sv
verif/sprite_frame_animation_player_checker.sv
verif/sprite_frame_animation_player_test.sv
